@@ hw/rtl/rpps_pkg.sv @@
// rpps_pkg: shared types, constants and point offsets for the rounded panel pixel shader
// no dependencies; imported by every module of the block
`default_nettype none

package rpps_pkg;

  // field widths
  localparam int PIX_W    = 12;
  localparam int COORD_W  = 14;
  localparam int SIZE_W   = 11;
  localparam int RAD_W    = 10;
  localparam int R2_W     = 2 * RAD_W;
  localparam int MAG_W    = 13;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int COLOR_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CH_PROD_W = 16;

  // frame defaults
  localparam int DEF_FRAME_WIDTH  = 1024;
  localparam int DEF_FRAME_HEIGHT = 768;

  // cycles from an accepting edge to the edge that takes the result
  localparam int RESULT_LATENCY = 7;

  // fixed colors
  localparam logic [COLOR_W-1:0] SHADOW_NEAR = 32'h1A00_0000;
  localparam logic [COLOR_W-1:0] SHADOW_FAR  = 32'h0D00_0000;
  localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0]         ALPHA_CLEAR  = 8'h00;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRAW_MODE     = 3'd0,
    CFG_RECT_LEFT     = 3'd1,
    CFG_RECT_TOP      = 3'd2,
    CFG_RECT_WIDTH    = 3'd3,
    CFG_RECT_HEIGHT   = 3'd4,
    CFG_CORNER_RADIUS = 3'd5,
    CFG_FILL_COLOR    = 3'd6,
    CFG_EDGE_COLOR    = 3'd7
  } cfg_reg_e;

  // draw modes
  localparam logic MODE_PANEL = 1'b0;
  localparam logic MODE_BOX   = 1'b1;

  // probe points for the corner test, relative to the pixel
  localparam int NUM_PTS  = 7;
  localparam int PT_SELF  = 0;
  localparam int PT_SH1   = 1;
  localparam int PT_SH2   = 2;
  localparam int PT_LEFT  = 3;
  localparam int PT_RIGHT = 4;
  localparam int PT_UP    = 5;
  localparam int PT_DOWN  = 6;
  localparam int OFF_X [NUM_PTS] = '{0, -2, -4, -1, 1, 0, 0};
  localparam int OFF_Y [NUM_PTS] = '{0, -3, -5, 0, 0, -1, 1};

  // geometry derived from the configuration registers
  typedef struct packed {
    logic signed [COORD_W-1:0] lcx;
    logic signed [COORD_W-1:0] rcx;
    logic signed [COORD_W-1:0] tcy;
    logic signed [COORD_W-1:0] bcy;
    logic        [R2_W-1:0]    r2;
    logic signed [COORD_W-1:0] xleft;
    logic signed [COORD_W-1:0] xlo;
    logic signed [COORD_W-1:0] xhi;
    logic signed [COORD_W-1:0] xend;
    logic signed [COORD_W-1:0] xlast;
    logic signed [COORD_W-1:0] ytop;
    logic signed [COORD_W-1:0] ylo;
    logic signed [COORD_W-1:0] yhi;
    logic signed [COORD_W-1:0] yend;
    logic signed [COORD_W-1:0] ylast;
  } geom_t;

  // per-pixel side info that travels next to the corner tests
  typedef struct packed {
    logic               in_win;
    logic               box_win;
    logic               edge_line;
    logic               in_frame;
    logic [COLOR_W-1:0] dst;
  } side_t;

endpackage

`default_nettype wire

@@ hw/rtl/rounded_panel_pixel_shader.sv @@
// rounded_panel_pixel_shader: top level, configuration registers, pixel pipeline and blend
// depends on rpps_pkg and rpps_corner_test
`default_nettype none

// Shades one pixel of a rounded rectangle per request.
// Configuration: cfg_we_i, cfg_addr_i and cfg_wdata_i write one register per edge; write
// only while no request is in flight. The new values apply to a request started in the
// next cycle or later.
// Request channel: a pixel (pixel_x_i, pixel_y_i, dest_color_i) is taken at an edge where
// start_i is high and busy_o is low. busy_o is high during reset and for the first cycle
// after it, and low from then on, so a new request may start in every cycle.
// Result channel: result_valid_o is high for one cycle per request, 6 register stages after the
// input register, carrying write_enable_o and new_color_o. Results leave in request order, one per
// clock at full rate.
// The pipeline: input register, three stages of corner testing for seven probe points
// (quadrant and distance, squares, radius compare), pixel class and color select,
// per-channel blend products, divide by 255 into the output register.
// The receiver cannot hold results off; there is no back pressure on either side.
// Reset clears the configuration to its defaults and empties the pipeline.

module rounded_panel_pixel_shader import rpps_pkg::*; #(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [COLOR_W-1:0]         cfg_wdata_i,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic signed [PIX_W-1:0]    pixel_x_i,
  input  logic signed [PIX_W-1:0]    pixel_y_i,
  input  logic [COLOR_W-1:0]         dest_color_i,
  output logic                       result_valid_o,
  output logic                       write_enable_o,
  output logic [COLOR_W-1:0]         new_color_o
);

  localparam logic signed [COORD_W-1:0] FrameW = COORD_W'(FRAME_WIDTH);
  localparam logic signed [COORD_W-1:0] FrameH = COORD_W'(FRAME_HEIGHT);

  // configuration registers
  logic                      draw_mode_q;
  logic signed [PIX_W-1:0]   rect_left_q, rect_top_q;
  logic [SIZE_W-1:0]         rect_width_q, rect_height_q;
  logic [RAD_W-1:0]          corner_radius_q;
  logic [COLOR_W-1:0]        fill_color_q, edge_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_mode_q     <= MODE_PANEL;
      rect_left_q     <= '0;
      rect_top_q      <= '0;
      rect_width_q    <= SIZE_W'(1);
      rect_height_q   <= SIZE_W'(1);
      corner_radius_q <= '0;
      fill_color_q    <= '0;
      edge_color_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_DRAW_MODE:     draw_mode_q     <= cfg_wdata_i[0];
        CFG_RECT_LEFT:     rect_left_q     <= cfg_wdata_i[PIX_W-1:0];
        CFG_RECT_TOP:      rect_top_q      <= cfg_wdata_i[PIX_W-1:0];
        CFG_RECT_WIDTH:    rect_width_q    <= cfg_wdata_i[SIZE_W-1:0];
        CFG_RECT_HEIGHT:   rect_height_q   <= cfg_wdata_i[SIZE_W-1:0];
        CFG_CORNER_RADIUS: corner_radius_q <= cfg_wdata_i[RAD_W-1:0];
        CFG_FILL_COLOR:    fill_color_q    <= cfg_wdata_i;
        CFG_EDGE_COLOR:    edge_color_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // derived geometry, refreshed every cycle
  logic signed [COORD_W-1:0] left_e, top_e, w_e, h_e, r_e;
  geom_t                     geom_d, geom_q;

  always_comb begin
    left_e = COORD_W'(rect_left_q);
    top_e  = COORD_W'(rect_top_q);
    w_e    = $signed(COORD_W'(rect_width_q));
    h_e    = $signed(COORD_W'(rect_height_q));
    r_e    = $signed(COORD_W'(corner_radius_q));
    geom_d.lcx   = left_e + r_e;
    geom_d.rcx   = left_e + w_e - r_e - COORD_W'(1);
    geom_d.tcy   = top_e + r_e;
    geom_d.bcy   = top_e + h_e - r_e - COORD_W'(1);
    geom_d.r2    = corner_radius_q * corner_radius_q;
    geom_d.xleft = left_e;
    geom_d.xlo   = left_e - COORD_W'(2);
    geom_d.xhi   = left_e + w_e + COORD_W'(4);
    geom_d.xend  = left_e + w_e;
    geom_d.xlast = left_e + w_e - COORD_W'(1);
    geom_d.ytop  = top_e;
    geom_d.ylo   = top_e - COORD_W'(2);
    geom_d.yhi   = top_e + h_e + COORD_W'(4);
    geom_d.yend  = top_e + h_e;
    geom_d.ylast = top_e + h_e - COORD_W'(1);
  end

  always_ff @(posedge clk_i) begin
    geom_q <= geom_d;
  end

  // request acceptance
  logic busy_q, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i & ~busy_q;

  // input register
  logic                    v0_q;
  logic signed [PIX_W-1:0] x0_q, y0_q;
  logic [COLOR_W-1:0]      dst0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q   <= pixel_x_i;
      y0_q   <= pixel_y_i;
      dst0_q <= dest_color_i;
    end
  end

  // window, border line and frame tests
  logic signed [COORD_W-1:0] x_e, y_e;
  side_t                     side0;

  always_comb begin
    x_e = COORD_W'(x0_q);
    y_e = COORD_W'(y0_q);
    side0.in_win    = (x_e >= $signed(geom_q.xlo)) && (x_e < $signed(geom_q.xhi)) &&
                      (y_e >= $signed(geom_q.ylo)) && (y_e < $signed(geom_q.yhi));
    side0.box_win   = (x_e >= $signed(geom_q.xleft)) && (x_e < $signed(geom_q.xend)) &&
                      (y_e >= $signed(geom_q.ytop)) && (y_e < $signed(geom_q.yend));
    side0.edge_line = (x_e == $signed(geom_q.xleft)) || (x_e == $signed(geom_q.xlast)) ||
                      (y_e == $signed(geom_q.ytop)) || (y_e == $signed(geom_q.ylast));
    side0.in_frame  = (x_e >= COORD_W'(0)) && (x_e < FrameW) &&
                      (y_e >= COORD_W'(0)) && (y_e < FrameH);
    side0.dst       = dst0_q;
  end

  // corner tests for the pixel, its shadow sources and its four neighbors
  logic [NUM_PTS-1:0] outs3;

  for (genvar i = 0; i < NUM_PTS; i++) begin : g_pt
    logic signed [COORD_W-1:0] px, py;
    assign px = x_e + COORD_W'(OFF_X[i]);
    assign py = y_e + COORD_W'(OFF_Y[i]);
    rpps_corner_test u_corner (
      .clk_i  (clk_i),
      .geom_i (geom_q),
      .px_i   (px),
      .py_i   (py),
      .out_o  (outs3[i])
    );
  end

  // side info delayed to line up with the corner results
  logic  v1_q, v2_q, v3_q;
  side_t side1_q, side2_q, side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q <= side0;
    side2_q <= side1_q;
    side3_q <= side2_q;
  end

  // pixel class and color select
  logic               have, is_edge, we4_d;
  logic [COLOR_W-1:0] color4_d;
  logic [7:0]         alpha4;

  always_comb begin
    have     = 1'b0;
    color4_d = '0;
    is_edge  = side3_q.edge_line | outs3[PT_LEFT] | outs3[PT_RIGHT] |
               outs3[PT_UP] | outs3[PT_DOWN];
    if (draw_mode_q == MODE_PANEL) begin
      if (side3_q.in_win) begin
        if (outs3[PT_SELF]) begin
          priority if (!outs3[PT_SH1]) begin
            color4_d = SHADOW_NEAR;
            have     = 1'b1;
          end else if (!outs3[PT_SH2]) begin
            color4_d = SHADOW_FAR;
            have     = 1'b1;
          end else begin
            // beyond both shadow levels
            have     = 1'b0;
          end
        end else begin
          color4_d = is_edge ? edge_color_q : fill_color_q;
          have     = 1'b1;
        end
      end
    end else begin
      if (side3_q.box_win && !outs3[PT_SELF]) begin
        color4_d = fill_color_q;
        have     = 1'b1;
      end
    end
    alpha4 = color4_d[31:24];
    we4_d  = have & side3_q.in_frame & (alpha4 != ALPHA_CLEAR);
  end

  logic               v4_q, we4_q;
  logic [COLOR_W-1:0] color4_q, dst4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    we4_q    <= we4_d;
    color4_q <= color4_d;
    dst4_q   <= side3_q.dst;
  end

  // blend products per channel: s*a + d*(255-a)
  logic [7:0]           a4, na4;
  logic [CH_PROD_W-1:0] prod5_d [3];

  always_comb begin
    a4  = color4_q[31:24];
    na4 = ALPHA_OPAQUE - a4;
    for (int c = 0; c < 3; c++) begin
      prod5_d[c] = CH_PROD_W'(color4_q[8*c +: 8] * a4) + CH_PROD_W'(dst4_q[8*c +: 8] * na4);
    end
  end

  logic                 v5_q, we5_q, direct5_q;
  logic [COLOR_W-1:0]   color5_q;
  logic [CH_PROD_W-1:0] prod5_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    we5_q     <= we4_q;
    direct5_q <= (a4 == ALPHA_OPAQUE);
    color5_q  <= color4_q;
    prod5_q   <= prod5_d;
  end

  // divide by 255: (v + 1 + (v >> 8)) >> 8 is exact for 16-bit v below 65535
  logic [CH_PROD_W:0]  q_tmp [3];
  logic [COLOR_W-1:0]  blended, color_d;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q_tmp[c] = (CH_PROD_W+1)'(prod5_q[c]) + (CH_PROD_W+1)'(1) +
                 (CH_PROD_W+1)'(prod5_q[c] >> 8);
    end
    blended = {ALPHA_OPAQUE, q_tmp[2][15:8], q_tmp[1][15:8], q_tmp[0][15:8]};
    if (!we5_q) begin
      color_d = '0;
    end else if (direct5_q) begin
      color_d = color5_q;
    end else begin
      color_d = blended;
    end
  end

  // output register
  logic               res_valid_q, res_we_q;
  logic [COLOR_W-1:0] res_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_we_q    <= 1'b0;
      res_color_q <= '0;
    end else begin
      res_valid_q <= v5_q;
      res_we_q    <= v5_q & we5_q;
      res_color_q <= v5_q ? color_d : '0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign write_enable_o = res_we_q;
  assign new_color_o    = res_color_q;

endmodule

`default_nettype wire

@@ hw/rtl/rpps_corner_test.sv @@
// rpps_corner_test: three-stage test whether one point lies in a rounded-off corner
// depends on rpps_pkg (geom_t, widths)
`default_nettype none

module rpps_corner_test import rpps_pkg::*; (
  input  logic                      clk_i,
  input  geom_t                     geom_i,
  input  logic signed [COORD_W-1:0] px_i,
  input  logic signed [COORD_W-1:0] py_i,
  output logic                      out_o
);

  logic                      left, right, top, bot;
  logic signed [COORD_W:0]   hdiff, vdiff;
  logic                      inq1_q, inq2_q, out3_q;
  logic        [MAG_W-1:0]   hx1_q, vy1_q;
  logic        [SQ_W-1:0]    hx2_q, vy2_q;
  logic        [SQ_W:0]      dist2;

  // quadrant select and distance to the chosen corner center
  always_comb begin
    left  = px_i < $signed(geom_i.lcx);
    right = px_i > $signed(geom_i.rcx);
    top   = py_i < $signed(geom_i.tcy);
    bot   = py_i > $signed(geom_i.bcy);
    if (left) begin
      hdiff = (COORD_W+1)'($signed(geom_i.lcx)) - (COORD_W+1)'(px_i);
    end else begin
      hdiff = (COORD_W+1)'(px_i) - (COORD_W+1)'($signed(geom_i.rcx));
    end
    if (top) begin
      vdiff = (COORD_W+1)'($signed(geom_i.tcy)) - (COORD_W+1)'(py_i);
    end else begin
      vdiff = (COORD_W+1)'(py_i) - (COORD_W+1)'($signed(geom_i.bcy));
    end
  end

  always_ff @(posedge clk_i) begin
    inq1_q <= (left | right) & (top | bot);
    hx1_q  <= hdiff[MAG_W-1:0];
    vy1_q  <= vdiff[MAG_W-1:0];
  end

  // squares
  always_ff @(posedge clk_i) begin
    inq2_q <= inq1_q;
    hx2_q  <= hx1_q * hx1_q;
    vy2_q  <= vy1_q * vy1_q;
  end

  // compare against the squared radius
  assign dist2 = (SQ_W+1)'(hx2_q) + (SQ_W+1)'(vy2_q);

  always_ff @(posedge clk_i) begin
    out3_q <= inq2_q & (dist2 > (SQ_W+1)'(geom_i.r2));
  end

  assign out_o = out3_q;

endmodule

`default_nettype wire

@@ hw/rtl/rpps_checker.sv @@
// rpps_checker: port-level assertions for the rounded panel pixel shader, bound to the top
// depends on rpps_pkg (RESULT_LATENCY, widths, alpha constant)
`default_nettype none

module rpps_checker import rpps_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    start_i,
  input wire logic                    busy_o,
  input wire logic                    result_valid_o,
  input wire logic                    write_enable_o,
  input wire logic [COLOR_W-1:0]      new_color_o
);

  // every accepted request yields one result at the fixed latency
  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##RESULT_LATENCY result_valid_o)
    else $error("accepted request produced no result at the expected latency");

  // no result without a request at the fixed latency
  a_result_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, RESULT_LATENCY))
    else $error("result without a matching request");

  // a write is always opaque: direct color at full alpha or a blended word
  a_write_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_enable_o |-> (result_valid_o && (new_color_o[31:24] == ALPHA_OPAQUE)))
    else $error("write without strobe or with non-opaque alpha");

  // a skipped pixel carries a zero word
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !write_enable_o) |-> (new_color_o == '0))
    else $error("skipped pixel with nonzero color");

endmodule

bind rounded_panel_pixel_shader rpps_checker u_rpps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .write_enable_o (write_enable_o),
  .new_color_o    (new_color_o)
);

`default_nettype wire

@@ bench/tb.sv @@
// tb: self-checking bench for rounded_panel_pixel_shader, driver and monitor as clocked blocks
// depends on rpps_pkg and the rounded_panel_pixel_shader rtl; needs no files or arguments
`timescale 1ns / 1ps

module tb;
  import rpps_pkg::*;

  localparam int PHASES        = 10;
  localparam int PIXELS_IN_PHASE = 125;
  localparam int STALL_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic [COLOR_W-1:0]      dst;
  } pixel_req_t;

  typedef struct {
    logic               we;
    logic [COLOR_W-1:0] color;
  } shade_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_addr_i = '0;
  logic [COLOR_W-1:0]      cfg_wdata_i = '0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic signed [PIX_W-1:0] pixel_x_i = '0;
  logic signed [PIX_W-1:0] pixel_y_i = '0;
  logic [COLOR_W-1:0]      dest_color_i = '0;
  logic                    result_valid_o;
  logic                    write_enable_o;
  logic [COLOR_W-1:0]      new_color_o;

  // shader settings as last written
  logic                    mode_q = MODE_PANEL;
  logic signed [PIX_W-1:0] left_q = '0;
  logic signed [PIX_W-1:0] top_q = '0;
  logic [SIZE_W-1:0]       width_q = 11'd1;
  logic [SIZE_W-1:0]       height_q = 11'd1;
  logic [RAD_W-1:0]        radius_q = '0;
  logic [COLOR_W-1:0]      fill_q = '0;
  logic [COLOR_W-1:0]      border_q = '0;

  pixel_req_t pending_pixels[$];
  shade_t     expected_shades[$];
  int         idle_pct = 0;
  int         stall_cycles = 0;
  int         mismatches = 0;

  rounded_panel_pixel_shader dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .start_i,
    .busy_o,
    .pixel_x_i,
    .pixel_y_i,
    .dest_color_i,
    .result_valid_o,
    .write_enable_o,
    .new_color_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // corner quadrant test against the current rounded rectangle
  function automatic bit corner_far(longint dx, longint dy, longint r);
    return dx * dx + dy * dy > r * r;
  endfunction

  function automatic bit outside_rounded(longint px, longint py);
    longint r, lcx, rcx, tcy, bcy;
    r   = longint'(radius_q);
    lcx = longint'(left_q) + r;
    rcx = longint'(left_q) + longint'(width_q) - r - 1;
    tcy = longint'(top_q) + r;
    bcy = longint'(top_q) + longint'(height_q) - r - 1;
    if (px < lcx && py < tcy) return corner_far(px - lcx, py - tcy, r);
    if (px > rcx && py < tcy) return corner_far(px - rcx, py - tcy, r);
    if (px < lcx && py > bcy) return corner_far(px - lcx, py - bcy, r);
    if (px > rcx && py > bcy) return corner_far(px - rcx, py - bcy, r);
    return 1'b0;
  endfunction

  // per-channel source-over blend, result forced opaque
  function automatic logic [COLOR_W-1:0] blend_over(logic [COLOR_W-1:0] src,
                                                    logic [COLOR_W-1:0] dst);
    logic [COLOR_W-1:0] res;
    int a, s, d;
    res = {ALPHA_OPAQUE, 24'h0};
    a = int'(src[31:24]);
    for (int ch = 0; ch < 3; ch++) begin
      s = int'(src[8*ch +: 8]);
      d = int'(dst[8*ch +: 8]);
      res[8*ch +: 8] = 8'((s * a + d * (255 - a)) / 255);
    end
    return res;
  endfunction

  // class the pixel and work out the word written back
  function automatic shade_t shade_pixel(pixel_req_t p);
    longint x, y, l, t, w, h;
    bit hit, on_border;
    logic [COLOR_W-1:0] col;
    shade_t none;
    x = longint'(p.x);
    y = longint'(p.y);
    l = longint'(left_q);
    t = longint'(top_q);
    w = longint'(width_q);
    h = longint'(height_q);
    hit = 1'b0;
    col = '0;
    none = '{1'b0, '0};
    if (mode_q == MODE_PANEL) begin
      if (x >= l - 2 && x < l + w + 4 && y >= t - 2 && y < t + h + 4) begin
        if (outside_rounded(x, y)) begin
          if (!outside_rounded(x - 2, y - 3)) begin
            col = SHADOW_NEAR;
            hit = 1'b1;
          end else if (!outside_rounded(x - 4, y - 5)) begin
            col = SHADOW_FAR;
            hit = 1'b1;
          end
        end else begin
          on_border = x == l || x == l + w - 1 || y == t || y == t + h - 1 ||
                      outside_rounded(x - 1, y) || outside_rounded(x + 1, y) ||
                      outside_rounded(x, y - 1) || outside_rounded(x, y + 1);
          col = on_border ? border_q : fill_q;
          hit = 1'b1;
        end
      end
    end else if (x >= l && x < l + w && y >= t && y < t + h && !outside_rounded(x, y)) begin
      col = fill_q;
      hit = 1'b1;
    end
    if (!hit || x < 0 || x >= DEF_FRAME_WIDTH || y < 0 || y >= DEF_FRAME_HEIGHT) return none;
    if (col[31:24] == ALPHA_OPAQUE) return '{1'b1, col};
    if (col[31:24] != ALPHA_CLEAR) return '{1'b1, blend_over(col, p.dst)};
    return none;
  endfunction

  // request driver: head of the pending queue, held until taken
  always @(negedge clk_i) begin
    if (rst_ni && pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start_i      <= 1'b1;
      pixel_x_i    <= pending_pixels[0].x;
      pixel_y_i    <= pending_pixels[0].y;
      dest_color_i <= pending_pixels[0].dst;
    end else begin
      start_i <= 1'b0;
    end
  end

  task automatic note_mismatch(string what, shade_t want, shade_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected we=%0b color=%08h, got we=%0b color=%08h",
               $realtime, what, want.we, want.color, got.we, got.color);
  endtask

  // monitor: predict on each taken request, check each result strobe
  always @(posedge clk_i) begin : monitor
    pixel_req_t taken;
    shade_t got, want;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (start_i && !busy_o) begin
        taken = '{pixel_x_i, pixel_y_i, dest_color_i};
        expected_shades.push_back(shade_pixel(taken));
        void'(pending_pixels.pop_front());
        moved = 1'b1;
      end
      if (result_valid_o) begin
        got = '{write_enable_o, new_color_o};
        moved = 1'b1;
        if (expected_shades.size() == 0) begin
          note_mismatch("result with no request outstanding", '{1'b0, '0}, got);
        end else begin
          want = expected_shades.pop_front();
          if (got.we !== want.we || got.color !== want.color)
            note_mismatch("pixel result differs", want, got);
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("rounded_panel_pixel_shader verification failed");
    $finish;
  end

  // register write; the shadow copy follows right away since nothing is in flight
  task automatic set_reg(cfg_reg_e idx, logic [COLOR_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_DRAW_MODE:     mode_q = val[0];
      CFG_RECT_LEFT:     left_q = val[PIX_W-1:0];
      CFG_RECT_TOP:      top_q = val[PIX_W-1:0];
      CFG_RECT_WIDTH:    width_q = val[SIZE_W-1:0];
      CFG_RECT_HEIGHT:   height_q = val[SIZE_W-1:0];
      CFG_CORNER_RADIUS: radius_q = val[RAD_W-1:0];
      CFG_FILL_COLOR:    fill_q = val;
      CFG_EDGE_COLOR:    border_q = val;
      default: ;
    endcase
  endtask

  // full reprogram, unused upper data bits carry noise
  task automatic apply_config(logic mode, int l, int t, int w, int h, int r,
                              logic [COLOR_W-1:0] fill, logic [COLOR_W-1:0] border);
    set_reg(CFG_DRAW_MODE, {31'($urandom()), mode});
    set_reg(CFG_RECT_LEFT, {20'($urandom()), 12'(l)});
    set_reg(CFG_RECT_TOP, {20'($urandom()), 12'(t)});
    set_reg(CFG_RECT_WIDTH, {21'($urandom()), 11'(w)});
    set_reg(CFG_RECT_HEIGHT, {21'($urandom()), 11'(h)});
    set_reg(CFG_CORNER_RADIUS, {22'($urandom()), 10'(r)});
    set_reg(CFG_FILL_COLOR, fill);
    set_reg(CFG_EDGE_COLOR, border);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold off until every request has come back, then let the pipe settle
  task automatic drain();
    while (pending_pixels.size() > 0 || expected_shades.size() > 0) @(negedge clk_i);
    repeat (RESULT_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic push_pixel(int x, int y, logic [COLOR_W-1:0] dst);
    pending_pixels.push_back('{12'(x), 12'(y), dst});
  endtask

  function automatic logic [COLOR_W-1:0] rand_argb();
    case ($urandom_range(4))
      0:       return {ALPHA_CLEAR, 24'($urandom())};
      1:       return {ALPHA_OPAQUE, 24'($urandom())};
      2:       return {8'h01, 24'($urandom())};
      3:       return {8'hFE, 24'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  function automatic int rand_size();
    if ($urandom_range(9) == 0) return $urandom_range(2047);
    return $urandom_range(40);
  endfunction

  function automatic int rand_origin(int span);
    if ($urandom_range(9) == 0) return int'($urandom_range(4095)) - 2048;
    return int'($urandom_range(span + 60)) - 30;
  endfunction

  task automatic rand_config();
    int w, h, r, shortest;
    w = rand_size();
    h = rand_size();
    shortest = (w < h) ? w : h;
    r = ($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(shortest / 2 + 2);
    apply_config(1'($urandom_range(1)), rand_origin(DEF_FRAME_WIDTH),
                 rand_origin(DEF_FRAME_HEIGHT), w, h, r, rand_argb(), rand_argb());
  endtask

  // mostly pixels in and around the scan window, some anywhere
  task automatic push_rand_pixel();
    if ($urandom_range(99) < 15) begin
      push_pixel($urandom(), $urandom(), $urandom());
    end else begin
      push_pixel(int'(left_q) - 6 + int'($urandom_range(int'(width_q) + 12)),
                 int'(top_q) - 6 + int'($urandom_range(int'(height_q) + 12)),
                 $urandom());
    end
  endtask

  initial begin
    int idle_by_phase [4] = '{0, 81, 0, 17};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: single-pixel panel, clear colors, shadow still drawn
    push_pixel(0, 0, 32'hFFFF_FFFF);
    push_pixel(2, 3, 32'h0000_0000);
    push_pixel(4, 5, 32'hFFFF_FFFF);
    push_pixel(1, 1, 32'h0000_0000);
    push_pixel(-2048, -2048, 32'h0000_0000);
    push_pixel(2047, 2047, 32'hFFFF_FFFF);
    drain();

    // panel: corners, shadow levels, border ring, fill
    apply_config(MODE_PANEL, 10, 10, 20, 12, 5, 32'h8012_3456, 32'hFF00_FF00);
    push_pixel(10, 10, 32'h00FF_FFFF);
    push_pixel(11, 11, 32'h0012_3456);
    push_pixel(12, 13, 32'hFFFF_FFFF);
    push_pixel(14, 15, 32'h0000_0000);
    push_pixel(20, 16, 32'h00FF_00FF);
    push_pixel(10, 16, 32'h0000_0000);
    push_pixel(29, 16, 32'h0000_0000);
    push_pixel(20, 21, 32'h0000_0000);
    push_pixel(20, 10, 32'h0000_0000);
    push_pixel(31, 23, 32'hFFFF_FFFF);
    push_pixel(33, 25, 32'h0080_8080);
    push_pixel(8, 8, 32'h0000_0000);
    push_pixel(7, 7, 32'h0000_0000);
    drain();

    // box at the frame corner: inside, clipped by frame, outside the box
    apply_config(MODE_BOX, 1000, 760, 30, 20, 0, 32'hFFAB_CDEF, 32'h0000_0000);
    push_pixel(1023, 767, 32'h0000_0000);
    push_pixel(1024, 767, 32'h0000_0000);
    push_pixel(1000, 760, 32'hFFFF_FFFF);
    push_pixel(999, 760, 32'h0000_0000);
    push_pixel(1029, 779, 32'h0000_0000);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct = idle_by_phase[ph % 4];
      case (ph)
        0: apply_config(MODE_PANEL, -2048, -2048, 2047, 2047, 1023, rand_argb(), rand_argb());
        1: apply_config(MODE_PANEL, 2047, 2047, 0, 1, 0, rand_argb(), rand_argb());
        2: apply_config(MODE_BOX, 0, 0, 2047, 2047, 1023, rand_argb(), rand_argb());
        3: apply_config(MODE_BOX, 5, 5, 0, 0, 0, 32'hFF00_0000, 32'hFFFF_FFFF);
        default: rand_config();
      endcase
      for (int i = 0; i < PIXELS_IN_PHASE; i++) begin
        push_rand_pixel();
        // now and then move to a fresh setting mid-phase
        if (i % 25 == 24 && ph >= 4) begin
          drain();
          rand_config();
        end
      end
      drain();
    end

    idle_pct = 0;
    drain();
    if (mismatches == 0 && expected_shades.size() == 0) begin
      $display("rounded_panel_pixel_shader verification clean");
    end else begin
      $display("rounded_panel_pixel_shader verification failed");
    end
    $finish;
  end

endmodule
